### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers used by tempo_clock_generator
// ----------------------------------------------------------------------------

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock, held off while reset is asserted
`define TCG_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// same check, for properties that must hold even during reset
`define TCG_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");

`endif

### design/tcg_pkg.sv
// ----------------------------------------------------------------------------
// tcg_pkg
// shared types and constants of the tempo clock generator
// ----------------------------------------------------------------------------
`default_nettype none

package tcg_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_BPM_TENTHS      = 3'd0;
	localparam logic [2:0] REG_SYNC_ENABLE     = 3'd1;
	localparam logic [2:0] REG_LOOP_LEN_LOG2   = 3'd2;
	localparam logic [2:0] REG_LOOP_START      = 3'd3;
	localparam logic [2:0] REG_TRIG_SPACE_LOG2 = 3'd4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 14;

	// commands
	localparam logic CMD_TICK    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// tempo limits and divisor, tenths of bpm per millisecond tick
	localparam logic [13:0] BPM_MIN   = 14'd1;
	localparam logic [13:0] BPM_MAX   = 14'd9999;
	localparam logic [13:0] BPM_RESET = 14'd1200;
	localparam longint      TEMPO_DIV = 37500;

	localparam logic [2:0] LOOP_LEN_MAX   = 3'd4;
	localparam logic [1:0] TRIG_SPACE_MAX = 2'd2;

	// pulse length in ticks
	localparam logic [1:0] PULSE_TICKS = 2'd2;

	typedef struct packed {
		logic       sync_enable;
		logic [2:0] loop_len_log2;
		logic [3:0] loop_start;
		logic [1:0] trig_space_log2;
	} tcg_cfg_t;

	typedef struct packed {
		logic cmd;
		logic sync_level;
	} tcg_item_t;

	typedef struct packed {
		logic [5:0] sub_step;
		logic [3:0] raw_step;
		logic [3:0] loop_step;
		logic       trigger;
	} tcg_result_t;

endpackage

`default_nettype wire

### design/tcg_if.sv
// ----------------------------------------------------------------------------
// tcg_in_if / tcg_out_if
// valid/ready channels for tick items and step results
// ----------------------------------------------------------------------------
`default_nettype none

interface tcg_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic sync_level;

	modport source (output valid, output cmd, output sync_level, input ready);
	modport sink (input valid, input cmd, input sync_level, output ready);
endinterface

interface tcg_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] sub_step;
	logic [3:0] raw_step;
	logic [3:0] loop_step;
	logic       trigger;

	modport source (
		output valid, output sub_step, output raw_step, output loop_step,
		output trigger, input ready
	);
	modport sink (
		input valid, input sub_step, input raw_step, input loop_step,
		input trigger, output ready
	);
endinterface

`default_nettype wire

### design/tempo_clock_generator.sv
// ----------------------------------------------------------------------------
// tempo_clock_generator
// sequencer tempo clock built on a phase accumulator
// ----------------------------------------------------------------------------
// One item is taken per clock cycle while the output is not stalled, and
// each gives one result through an input stage register, then the
// accumulator update and the result register. The rate is set by the phase
// update loop (phase register, one add, compare, back into the register).
// Tick ready depends combinationally on result ready, so a stalled output
// backs up through both stages. The internal tempo increment
// floor(bpm_tenths * 2^FRAC_BITS / 37500) is worked out when bpm_tenths is
// written, with one constant reciprocal multiply, and held in a register.
// Out-of-range register values are limited at the write.
`default_nettype none
`include "assert_macros.svh"

module tempo_clock_generator
	import tcg_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	tcg_in_if.sink                tick,
	tcg_out_if.source             result,
	input  wire                   cfg_we,
	input  wire [CFG_INDEX_W-1:0] cfg_index,
	input  wire [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int PW          = FRAC_BITS + 6;
	// reciprocal shift chosen so the truncated product is exact for any 14-bit tempo
	localparam int RECIP_SHIFT = 30;
	localparam int RECIP_W     = FRAC_BITS + RECIP_SHIFT;
	localparam longint RECIP_L =
		((64'sd1 <<< (FRAC_BITS + RECIP_SHIFT)) + TEMPO_DIV - 1) / TEMPO_DIV;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
	localparam longint INC_RESET_L = (64'(BPM_RESET) <<< FRAC_BITS) / TEMPO_DIV;
	localparam logic [FRAC_BITS-1:0] INC_RESET = FRAC_BITS'(INC_RESET_L);

	// configuration
	tcg_cfg_t             cfg_q;
	logic [FRAC_BITS-1:0] inc_q;
	logic [13:0]          bpm_lim;
	logic [RECIP_W-1:0]   inc_prod;

	// pipeline
	logic        valid_s1;
	tcg_item_t   item_s1;
	logic        valid_s2;
	tcg_result_t result_s2;
	logic        tick_xfer;
	logic        load_s2;

	// accumulator state
	logic [PW-1:0] phase_q;
	logic          sync_prev_q;
	logic [1:0]    pulse_q;

	logic [PW-1:0] phase_next;
	logic          sync_prev_next;
	logic [1:0]    pulse_next;
	tcg_result_t   step_result;

	// tempo limit and increment for the value being written
	always_comb begin
		if (cfg_wdata < BPM_MIN) begin
			bpm_lim = BPM_MIN;
		end else if (cfg_wdata > BPM_MAX) begin
			bpm_lim = BPM_MAX;
		end else begin
			bpm_lim = cfg_wdata;
		end
	end

	assign inc_prod = RECIP_W'(bpm_lim) * RECIP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q                 <= INC_RESET;
			cfg_q.sync_enable     <= 1'b0;
			cfg_q.loop_len_log2   <= LOOP_LEN_MAX;
			cfg_q.loop_start      <= 4'd0;
			cfg_q.trig_space_log2 <= TRIG_SPACE_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BPM_TENTHS: begin
					inc_q <= inc_prod[RECIP_W-1:RECIP_SHIFT];
				end
				REG_SYNC_ENABLE: begin
					cfg_q.sync_enable <= cfg_wdata[0];
				end
				REG_LOOP_LEN_LOG2: begin
					// lengths above sixteen steps act as sixteen
					cfg_q.loop_len_log2 <= (cfg_wdata[2:0] > LOOP_LEN_MAX) ?
						LOOP_LEN_MAX : cfg_wdata[2:0];
				end
				REG_LOOP_START: begin
					cfg_q.loop_start <= cfg_wdata[3:0];
				end
				REG_TRIG_SPACE_LOG2: begin
					// spacing above four sub-steps acts as four
					cfg_q.trig_space_log2 <= (cfg_wdata[1:0] > TRIG_SPACE_MAX) ?
						TRIG_SPACE_MAX : cfg_wdata[1:0];
				end
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	// handshake: stage two loads when its slot is empty or being drained
	assign load_s2    = valid_s1 && (!valid_s2 || result.ready);
	assign tick.ready = !valid_s1 || load_s2;
	assign tick_xfer  = tick.valid && tick.ready;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_xfer) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_xfer) begin
			item_s1.cmd        <= tick.cmd;
			item_s1.sync_level <= tick.sync_level;
		end
	end

	tcg_step #(
		.FRAC_BITS (FRAC_BITS)
	) u_step (
		.item           (item_s1),
		.cfg            (cfg_q),
		.inc            (inc_q),
		.phase          (phase_q),
		.sync_prev      (sync_prev_q),
		.pulse          (pulse_q),
		.phase_next     (phase_next),
		.sync_prev_next (sync_prev_next),
		.pulse_next     (pulse_next),
		.result         (step_result)
	);

	// accumulator state moves only when an item enters the result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			sync_prev_q <= 1'b0;
			pulse_q     <= 2'd0;
		end else if (load_s2) begin
			phase_q     <= phase_next;
			sync_prev_q <= sync_prev_next;
			pulse_q     <= pulse_next;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2 <= step_result;
		end
	end

	assign result.valid     = valid_s2;
	assign result.sub_step  = result_s2.sub_step;
	assign result.raw_step  = result_s2.raw_step;
	assign result.loop_step = result_s2.loop_step;
	assign result.trigger   = result_s2.trigger;

	// a restart always reports the start of the bar
	`TCG_ASSERT(a_restart_zero, clk, arst_n,
		load_s2 && item_s1.cmd == CMD_RESTART |=> result_s2.sub_step == 6'd0)

	// reported trigger tracks the pulse counter it was taken from
	`TCG_ASSERT(a_trigger_matches, clk, arst_n,
		load_s2 |=> result_s2.trigger == (pulse_q != 2'd0))

	// accumulator holds while no item moves into the result stage
	`TCG_ASSERT(a_phase_hold, clk, arst_n,
		!load_s2 |=> $stable(phase_q) && $stable(pulse_q))

endmodule

`default_nettype wire

### design/tcg_step.sv
// ----------------------------------------------------------------------------
// tcg_step
// next-state and result logic for one tick or restart item
// ----------------------------------------------------------------------------
`default_nettype none

module tcg_step
	import tcg_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire tcg_item_t               item,
	input  wire tcg_cfg_t                cfg,
	input  wire [FRAC_BITS-1:0]          inc,
	input  wire [FRAC_BITS+5:0]          phase,
	input  wire                          sync_prev,
	input  wire [1:0]                    pulse,
	output logic [FRAC_BITS+5:0]         phase_next,
	output logic                         sync_prev_next,
	output logic [1:0]                   pulse_next,
	output tcg_result_t                  result
);

	localparam int PW = FRAC_BITS + 6;
	localparam logic [PW-1:0] SYNC_INC = {6'd4, {FRAC_BITS{1'b0}}};

	logic [5:0] prev_sub;
	logic [5:0] after;
	logic       spacing_hit;
	logic [3:0] len_mask;

	always_comb begin
		phase_next     = phase;
		sync_prev_next = sync_prev;
		pulse_next     = pulse;
		prev_sub       = phase[PW-1:FRAC_BITS];

		if (item.cmd == CMD_RESTART) begin
			phase_next = '0;
		end else begin
			if (cfg.sync_enable) begin
				if (item.sync_level && !sync_prev) begin
					phase_next = phase + SYNC_INC;
				end
				sync_prev_next = item.sync_level;
			end else begin
				phase_next = phase + {6'd0, inc};
			end
			if (pulse != 2'd0) begin
				pulse_next = pulse - 2'd1;
			end
		end

		after = phase_next[PW-1:FRAC_BITS];

		case (cfg.trig_space_log2)
			2'd0:    spacing_hit = 1'b1;
			2'd1:    spacing_hit = (after[0] == 1'b0);
			default: spacing_hit = (after[1:0] == 2'b00);
		endcase

		if (item.cmd == CMD_TICK && after != prev_sub && spacing_hit) begin
			pulse_next = PULSE_TICKS;
		end
	end

	// loop repeat mask, length register already limited to four
	always_comb begin
		case (cfg.loop_len_log2)
			3'd0:    len_mask = 4'b0000;
			3'd1:    len_mask = 4'b0001;
			3'd2:    len_mask = 4'b0011;
			3'd3:    len_mask = 4'b0111;
			default: len_mask = 4'b1111;
		endcase
	end

	always_comb begin
		result.sub_step  = after;
		result.raw_step  = after[5:2];
		result.loop_step = (after[5:2] & len_mask) + cfg.loop_start;
		result.trigger   = (pulse_next != 2'd0);
	end

endmodule

`default_nettype wire
